// ----- sv/pwm_timer_with_preload_defines.svh -----
// Assertion macros for the PWM timer with preload.
// Used by the port checker; expects clk and rst_n in the scope of use.
`ifndef PWM_TIMER_WITH_PRELOAD_DEFINES_SVH
`define PWM_TIMER_WITH_PRELOAD_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define PWT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PWT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/pwt_pkg.sv -----
// Shared types and constants of the PWM timer with preload.
// No dependencies; used by the top level, datapath, controller and checker.
`default_nettype none

package pwt_pkg;

  localparam int RESET_PERIOD = 1000;
  localparam int PERCENT      = 100;

  localparam int FREQ_W      = 16;
  localparam int DUTY_W      = 7;
  localparam int PSC_W       = 16;
  localparam int OUT_CNT_W   = 16;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_DATA_W   = 24;
  localparam int OUT_DATA_W  = 24;

  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_SET  = 1'b1;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_PRESCALE    = 3'd0,
    REG_MODE_TWO    = 3'd1,
    REG_ACTIVE_LOW  = 3'd2,
    REG_CHAN_EN     = 3'd3,
    REG_MAIN_EN     = 3'd4,
    REG_CNT_EN      = 3'd5,
    REG_PER_PRELOAD = 3'd6,
    REG_CMP_PRELOAD = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic tick_step;
    logic capture;
    logic div_start;
    logic quot_load;
    logic prod_load;
    logic cmp_load;
    logic apply_set;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
  } ctrl_sts_t;

endpackage

`default_nettype wire

// ----- sv/pwm_timer_with_preload.sv -----
// Up-counting edge-aligned PWM timer with preload registers: a tick and a
// set_pwm request each give one result transaction. Ticks pass at one per
// clock while the result side drains. A set_pwm request runs the serial
// divider, which forms one period quotient bit per cycle, then a registered
// multiply step and a registered reciprocal-scaling step for the compare value.
// No input is taken meanwhile. Configuration is to be written through the cfg
// port only while idle; the block itself does not enforce this.
`default_nettype none

module pwm_timer_with_preload #(
  parameter int CLOCK_HZ    = 4000000,
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // frequency [15:0], duty_percent [22:16], zero [23]
  input  wire logic [pwt_pkg::IN_DATA_W-1:0]      in_tdata,
  // action [0]
  input  wire logic                               in_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // pwm_out [0], count [16:1], update_event [17], zero [23:18]
  output logic [pwt_pkg::OUT_DATA_W-1:0]          out_tdata,
  input  wire logic                               cfg_we,
  input  wire logic [pwt_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire logic [pwt_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  pwt_pkg::ctrl_cmd_t cmd;
  pwt_pkg::ctrl_sts_t sts;
  logic                          res_pwm;
  logic [pwt_pkg::OUT_CNT_W-1:0] res_count;
  logic                          res_upd;

  pwt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_action  (in_tuser),
    .out_tready (out_tready),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .cmd        (cmd),
    .sts        (sts)
  );

  pwt_dp #(
    .CLOCK_HZ    (CLOCK_HZ),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_freq   (in_tdata[15:0]),
    .in_duty   (in_tdata[22:16]),
    .cmd       (cmd),
    .sts       (sts),
    .res_pwm   (res_pwm),
    .res_count (res_count),
    .res_upd   (res_upd)
  );

  assign out_tdata = {6'b0, res_upd, res_count, res_pwm};

endmodule

`default_nettype wire

// ----- sv/pwt_div.sv -----
// Serial restoring divider producing one quotient bit per cycle.
// Stand-alone; instantiated by the datapath.
`default_nettype none

module pwt_div #(
  parameter int DIVIDEND_W = 29,
  parameter int DIVISOR_W  = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [DIVISOR_W-1:0]  divisor,
  output logic                       done,
  output logic [DIVIDEND_W-1:0]      quotient
);

  localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIVIDEND_W - 1);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVISOR_W-1:0]  dvs_r, dvs_nxt;
  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  assign shifted = {rem_r, quo_r[DIVIDEND_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign fits    = shifted >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = LAST_STEP;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
      quo_nxt = {quo_r[DIVIDEND_W-2:0], fits};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// ----- sv/pwt_dp.sv -----
// Datapath: configuration, prescaler, main counter, period and compare registers,
// set_pwm arithmetic and the result register. Uses pwt_pkg and pwt_div.
`default_nettype none

module pwt_dp #(
  parameter int CLOCK_HZ    = 4000000,
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [pwt_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire logic [pwt_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire logic [pwt_pkg::FREQ_W-1:0]       in_freq,
  input  wire logic [pwt_pkg::DUTY_W-1:0]       in_duty,
  input  wire pwt_pkg::ctrl_cmd_t               cmd,
  output pwt_pkg::ctrl_sts_t                    sts,
  output logic                                  res_pwm,
  output logic [pwt_pkg::OUT_CNT_W-1:0]         res_count,
  output logic                                  res_upd
);

  localparam int CLK_W    = $clog2(CLOCK_HZ + 1);
  localparam int QUOT_W   = (CLK_W > COUNT_WIDTH) ? CLK_W : COUNT_WIDTH;
  localparam int PROD_W   = QUOT_W + pwt_pkg::DUTY_W;
  localparam int PCT_W    = $clog2(pwt_pkg::PERCENT);
  localparam int RECIP_SH = PROD_W + PCT_W;
  localparam int RECIP_W  = PROD_W + 1;
  localparam int SCALE_W  = PROD_W + RECIP_W;

  localparam logic [QUOT_W-1:0] QCNT_MAX = QUOT_W'({COUNT_WIDTH{1'b1}});
  localparam logic [PROD_W-1:0] PCNT_MAX = PROD_W'({COUNT_WIDTH{1'b1}});
  localparam logic [QUOT_W-1:0] CLK_DIVIDEND = QUOT_W'(CLOCK_HZ);
  localparam logic [RECIP_W-1:0] PCT_RECIP =
    RECIP_W'(((64'd1 << RECIP_SH) + 64'(pwt_pkg::PERCENT) - 64'd1) / 64'(pwt_pkg::PERCENT));
  localparam logic [COUNT_WIDTH-1:0] RST_PERIOD = COUNT_WIDTH'(pwt_pkg::RESET_PERIOD);

  logic [pwt_pkg::PSC_W-1:0] psc_lim_r;
  logic mode_two_r, active_low_r, chan_en_r, main_en_r, cnt_en_r;

  logic [pwt_pkg::PSC_W-1:0] psc_r, psc_nxt;
  logic [COUNT_WIDTH-1:0]    cnt_r, cnt_nxt;
  logic [COUNT_WIDTH-1:0]    per_act_r, per_act_nxt;
  logic [COUNT_WIDTH-1:0]    per_pre_r, per_pre_nxt;
  logic [COUNT_WIDTH-1:0]    cmp_act_r, cmp_act_nxt;
  logic [COUNT_WIDTH-1:0]    cmp_pre_r, cmp_pre_nxt;
  logic                      upd_nxt;

  logic [pwt_pkg::FREQ_W-1:0] freq_r;
  logic [pwt_pkg::DUTY_W-1:0] duty_r;
  logic [QUOT_W-1:0]          quot_r;
  logic [PROD_W-1:0]          prod_r;
  logic [PROD_W-1:0]          cmp_val_r;

  logic [QUOT_W-1:0]          div_quo;
  logic                       div_done;
  logic [SCALE_W-1:0]         cmp_scaled;

  logic [COUNT_WIDTH-1:0]     per_sat;
  logic [COUNT_WIDTH-1:0]     cmp_sat;
  logic                       level;

  logic                          res_pwm_r;
  logic [pwt_pkg::OUT_CNT_W-1:0] res_count_r;
  logic                          res_upd_r;

  // Preload enables need no storage: every period and compare write comes from
  // set_pwm, which always forces an update, so both settings behave the same.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      psc_lim_r    <= '0;
      mode_two_r   <= 1'b0;
      active_low_r <= 1'b0;
      chan_en_r    <= 1'b0;
      main_en_r    <= 1'b0;
      cnt_en_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        pwt_pkg::REG_PRESCALE:   psc_lim_r    <= cfg_wdata;
        pwt_pkg::REG_MODE_TWO:   mode_two_r   <= cfg_wdata[0];
        pwt_pkg::REG_ACTIVE_LOW: active_low_r <= cfg_wdata[0];
        pwt_pkg::REG_CHAN_EN:    chan_en_r    <= cfg_wdata[0];
        pwt_pkg::REG_MAIN_EN:    main_en_r    <= cfg_wdata[0];
        pwt_pkg::REG_CNT_EN:     cnt_en_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  pwt_div #(
    .DIVIDEND_W (QUOT_W),
    .DIVISOR_W  (pwt_pkg::FREQ_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (CLK_DIVIDEND),
    .divisor  (freq_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign sts.div_done = div_done;

  // The division by the percent scale is a multiplication by its rounded-up
  // reciprocal, exact for every product that fits in PROD_W bits.
  assign cmp_scaled = SCALE_W'(prod_r) * SCALE_W'(PCT_RECIP);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      freq_r <= in_freq;
      duty_r <= in_duty;
    end
    if (cmd.quot_load) begin
      quot_r <= (freq_r == '0) ? QCNT_MAX : div_quo;
    end
    if (cmd.prod_load) begin
      prod_r <= PROD_W'(quot_r) * PROD_W'(duty_r);
    end
    if (cmd.cmp_load) begin
      cmp_val_r <= PROD_W'(cmp_scaled >> RECIP_SH);
    end
  end

  assign per_sat = (quot_r > QCNT_MAX) ? '1 : quot_r[COUNT_WIDTH-1:0];
  assign cmp_sat = (cmp_val_r > PCNT_MAX) ? '1 : cmp_val_r[COUNT_WIDTH-1:0];

  always_comb begin
    psc_nxt     = psc_r;
    cnt_nxt     = cnt_r;
    per_act_nxt = per_act_r;
    per_pre_nxt = per_pre_r;
    cmp_act_nxt = cmp_act_r;
    cmp_pre_nxt = cmp_pre_r;
    upd_nxt     = 1'b0;
    if (cmd.apply_set) begin
      per_pre_nxt = per_sat;
      cmp_pre_nxt = cmp_sat;
      per_act_nxt = per_sat;
      cmp_act_nxt = cmp_sat;
      psc_nxt     = '0;
      cnt_nxt     = '0;
      upd_nxt     = 1'b1;
    end else if (cmd.tick_step && cnt_en_r) begin
      if (psc_r >= psc_lim_r) begin
        psc_nxt = '0;
        if (cnt_r == per_act_r) begin
          cnt_nxt     = '0;
          per_act_nxt = per_pre_r;
          cmp_act_nxt = cmp_pre_r;
          upd_nxt     = 1'b1;
        end else begin
          cnt_nxt = cnt_r + COUNT_WIDTH'(1);
        end
      end else begin
        psc_nxt = psc_r + pwt_pkg::PSC_W'(1);
      end
    end
  end

  assign level = ((cnt_nxt < cmp_act_nxt) ^ mode_two_r ^ active_low_r)
                 & chan_en_r & main_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      psc_r     <= '0;
      cnt_r     <= '0;
      per_act_r <= RST_PERIOD;
      per_pre_r <= RST_PERIOD;
      cmp_act_r <= '0;
      cmp_pre_r <= '0;
    end else begin
      psc_r     <= psc_nxt;
      cnt_r     <= cnt_nxt;
      per_act_r <= per_act_nxt;
      per_pre_r <= per_pre_nxt;
      cmp_act_r <= cmp_act_nxt;
      cmp_pre_r <= cmp_pre_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick_step || cmd.apply_set) begin
      res_pwm_r   <= level;
      res_count_r <= pwt_pkg::OUT_CNT_W'(cnt_nxt);
      res_upd_r   <= upd_nxt;
    end
  end

  assign res_pwm   = res_pwm_r;
  assign res_count = res_count_r;
  assign res_upd   = res_upd_r;

endmodule

`default_nettype wire

// ----- sv/pwt_ctrl.sv -----
// Controller: input and output handshakes and the set_pwm sequence.
// Uses pwt_pkg; drives the datapath through ctrl_cmd_t.
`default_nettype none

module pwt_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  input  wire logic            in_action,
  input  wire logic            out_tready,
  output logic                 in_tready,
  output logic                 out_tvalid,
  output pwt_pkg::ctrl_cmd_t   cmd,
  input  wire pwt_pkg::ctrl_sts_t sts
);

  typedef enum logic [5:0] {
    ST_IDLE      = 6'b000001,
    ST_PER_START = 6'b000010,
    ST_PER_WAIT  = 6'b000100,
    ST_MUL       = 6'b001000,
    ST_CMP       = 6'b010000,
    ST_APPLY     = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   accept;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && out_free;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_action == pwt_pkg::ACT_SET) begin
            cmd.capture = 1'b1;
            state_nxt   = ST_PER_START;
          end else begin
            cmd.tick_step = 1'b1;
          end
        end
      end
      ST_PER_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_PER_WAIT;
      end
      ST_PER_WAIT: begin
        if (sts.div_done) begin
          cmd.quot_load = 1'b1;
          state_nxt     = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.prod_load = 1'b1;
        state_nxt     = ST_CMP;
      end
      ST_CMP: begin
        cmd.cmp_load = 1'b1;
        state_nxt    = ST_APPLY;
      end
      ST_APPLY: begin
        if (out_free) begin
          cmd.apply_set = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid_nxt = (out_valid_r && !out_tready) || cmd.tick_step || cmd.apply_set;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

// ----- sv/pwt_checker.sv -----
// Port-level checker for the PWM timer with preload, bound to the top level.
// Uses pwt_pkg and the assertion macros of pwm_timer_with_preload_defines.svh.
`default_nettype none
`include "pwm_timer_with_preload_defines.svh"

module pwt_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tvalid,
  input wire logic                           in_tready,
  input wire logic [pwt_pkg::IN_DATA_W-1:0]  in_tdata,
  input wire logic                           in_tuser,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [pwt_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic                           cfg_we,
  input wire logic [pwt_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input wire logic [pwt_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  `PWT_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "Stalled result transaction changed.")
  `PWT_ASSERT_NEXT(a_tick_result, in_tvalid && in_tready && (in_tuser == pwt_pkg::ACT_TICK), out_tvalid, "Tick transaction gave no result in the next cycle.")
  `PWT_ASSERT_NEXT(a_set_busy, in_tvalid && in_tready && (in_tuser == pwt_pkg::ACT_SET), !out_tvalid && !in_tready, "Input was open or a result appeared right after set_pwm.")
  `PWT_ASSERT_SAME(a_no_accept_on_stall, out_tvalid && !out_tready, !in_tready, "Input accepted while a result is stalled.")
  `PWT_ASSERT_SAME(a_update_zero, out_tvalid && out_tdata[17], out_tdata[16:1] == 16'd0, "Update event with a nonzero count.")

endmodule

bind pwm_timer_with_preload pwt_checker u_pwt_checker (.*);

`default_nettype wire
